// ===== hw/rtl/ugcs_pkg.sv =====
// Shared types and constants for the uniform grid counting sort block.
// Used by ugcs_ctrl, ugcs_dp and the top level; no dependencies.
package ugcs_pkg;

  localparam int ID_W   = 16;
  localparam int POS_W  = 24;
  localparam int VEL_W  = 24;
  localparam int IDX_W  = 12;
  localparam int CELL_W = 12;
  localparam int SLOT_W = 13;
  localparam int GPA_W  = 5;
  localparam int ICS_W  = 16;
  localparam int CFG_W  = 16;

  localparam logic CFG_GRID = 1'b0;
  localparam logic CFG_INV  = 1'b1;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_SLOT = 2'd1,
    OP_CELL = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLR,
    S_MUL,
    S_CELL,
    S_CNT_RD,
    S_CNT_WR,
    S_SCAN,
    S_SCAT_A,
    S_SCAT_B,
    S_SCAT_C,
    S_RD_MAP,
    S_RD_REC,
    S_RD_CELL,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [POS_W-1:0] px;
    logic [POS_W-1:0] py;
    logic [POS_W-1:0] pz;
    logic [VEL_W-1:0] vx;
    logic [VEL_W-1:0] vy;
    logic [VEL_W-1:0] vz;
  } pay_t;

  typedef struct packed {
    logic latch;
    logic clr_init;
    logic clr_run;
    logic cell_calc;
    logic cnt_rd;
    logic cnt_wr;
    logic scan_init;
    logic scan_run;
    logic scat_init;
    logic scat_rec;
    logic scat_start;
    logic scat_wr;
    logic close;
    logic q_map;
    logic q_rec;
    logic q_cell;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic open;
    logic full;
    logic last;
    op_t  op;
    logic rd_ok;
    logic clr_done;
    logic scan_done;
    logic scat_done;
    logic out_busy;
  } sts_t;

endpackage

// ===== hw/rtl/uniform_grid_counting_sort.sv =====
// Top level of the uniform grid counting sort block.
// Depends on ugcs_pkg, ugcs_ctrl, ugcs_dp (and ugcs_ram through ugcs_dp).
//
// Usage: the input channel takes one word per command: load a particle,
// read a sorted slot, or read a cell's first slot and member count. Results
// (reads only) leave on the output channel, one word each. Config writes
// (grid_per_axis, inv_cell_size) are taken at any edge with cfg_we high.
// Sequencing, with C = MAX_GRID_AXIS cubed and N the batch size:
//   load: accept, multiply, cell, count read, count write; the first load of
//     a batch adds a count clear sweep over all C cells before it is processed.
//   last load: adds a scan of the C counts and a scatter of the N records.
//   read: accept, multiply, cell, then the map, record and cell RAM lookups
//     in series for a slot read, the cell lookup alone for a cell read, none
//     when the request is out of range; then the result is loaded.
// The next word is accepted while a result waits in the output register;
// a stalled result holds, and a later read waits for it to drain.
// Reset clears the batch state and the output valid flag; reads return
// valid_res = 0 until a batch has been closed.
module uniform_grid_counting_sort #(
  parameter int MAX_PARTICLES = 4096,
  parameter int MAX_GRID_AXIS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [ugcs_pkg::CFG_W-1:0]         cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         in_opcode,
  input  logic [ugcs_pkg::ID_W-1:0]          in_particle_id,
  input  logic [ugcs_pkg::POS_W-1:0]         in_pos_x,
  input  logic [ugcs_pkg::POS_W-1:0]         in_pos_y,
  input  logic [ugcs_pkg::POS_W-1:0]         in_pos_z,
  input  logic signed [ugcs_pkg::VEL_W-1:0]  in_vel_x,
  input  logic signed [ugcs_pkg::VEL_W-1:0]  in_vel_y,
  input  logic signed [ugcs_pkg::VEL_W-1:0]  in_vel_z,
  input  logic                               in_last_particle,
  input  logic [ugcs_pkg::IDX_W-1:0]         in_lookup_index,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_valid_res,
  output logic [ugcs_pkg::ID_W-1:0]          out_id,
  output logic [ugcs_pkg::POS_W-1:0]         out_pos_x,
  output logic [ugcs_pkg::POS_W-1:0]         out_pos_y,
  output logic [ugcs_pkg::POS_W-1:0]         out_pos_z,
  output logic signed [ugcs_pkg::VEL_W-1:0]  out_vel_x,
  output logic signed [ugcs_pkg::VEL_W-1:0]  out_vel_y,
  output logic signed [ugcs_pkg::VEL_W-1:0]  out_vel_z,
  output logic [ugcs_pkg::CELL_W-1:0]        out_cell,
  output logic [ugcs_pkg::SLOT_W-1:0]        out_cell_first_slot,
  output logic [ugcs_pkg::SLOT_W-1:0]        out_cell_members
);

  ugcs_pkg::cmd_t cmd;
  ugcs_pkg::sts_t sts;

  ugcs_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_opcode(in_opcode),
    .in_stall(in_stall), .sts(sts), .cmd(cmd)
  );

  ugcs_dp #(.MAX_PARTICLES(MAX_PARTICLES), .MAX_GRID_AXIS(MAX_GRID_AXIS)) u_dp (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_opcode(in_opcode), .in_particle_id(in_particle_id),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_pos_z(in_pos_z),
    .in_vel_x(in_vel_x), .in_vel_y(in_vel_y), .in_vel_z(in_vel_z),
    .in_last_particle(in_last_particle), .in_lookup_index(in_lookup_index),
    .cmd(cmd), .sts(sts),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_valid_res(out_valid_res), .out_id(out_id),
    .out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_pos_z(out_pos_z),
    .out_vel_x(out_vel_x), .out_vel_y(out_vel_y), .out_vel_z(out_vel_z),
    .out_cell(out_cell), .out_cell_first_slot(out_cell_first_slot),
    .out_cell_members(out_cell_members)
  );

endmodule

// ===== hw/rtl/ugcs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ugcs_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] wa,
  input  logic [W-1:0]         wd,
  input  logic                 re,
  input  logic [$clog2(D)-1:0] ra,
  output logic [W-1:0]         rd
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd <= mem[ra];
    end
  end

endmodule

// ===== hw/rtl/ugcs_ctrl.sv =====
// Controller state machine: sequences load, clear, scan, scatter and reads.
// Depends on ugcs_pkg; drives commands to ugcs_dp and reads its status.
module ugcs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_opcode,
  output logic              in_stall,
  input  ugcs_pkg::sts_t    sts,
  output ugcs_pkg::cmd_t    cmd
);

  ugcs_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ugcs_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ugcs_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.latch = 1'b1;
          case (ugcs_pkg::op_t'(in_opcode))
            ugcs_pkg::OP_LOAD: begin
              if (!sts.open) begin
                cmd.clr_init = 1'b1;
                state_nxt    = ugcs_pkg::S_CLR;
              end else begin
                state_nxt = ugcs_pkg::S_MUL;
              end
            end
            ugcs_pkg::OP_SLOT, ugcs_pkg::OP_CELL: state_nxt = ugcs_pkg::S_MUL;
            default: state_nxt = ugcs_pkg::S_IDLE;
          endcase
        end
      end
      ugcs_pkg::S_CLR: begin
        cmd.clr_run = 1'b1;
        if (sts.clr_done) begin
          state_nxt = ugcs_pkg::S_MUL;
        end
      end
      ugcs_pkg::S_MUL: state_nxt = ugcs_pkg::S_CELL;
      ugcs_pkg::S_CELL: begin
        cmd.cell_calc = 1'b1;
        if (sts.op == ugcs_pkg::OP_LOAD) begin
          if (!sts.full) begin
            state_nxt = ugcs_pkg::S_CNT_RD;
          end else if (sts.last) begin
            cmd.scan_init = 1'b1;
            state_nxt     = ugcs_pkg::S_SCAN;
          end else begin
            state_nxt = ugcs_pkg::S_IDLE;
          end
        end else if (!sts.rd_ok) begin
          state_nxt = ugcs_pkg::S_OUT;
        end else if (sts.op == ugcs_pkg::OP_SLOT) begin
          state_nxt = ugcs_pkg::S_RD_MAP;
        end else begin
          state_nxt = ugcs_pkg::S_RD_CELL;
        end
      end
      ugcs_pkg::S_CNT_RD: begin
        cmd.cnt_rd = 1'b1;
        state_nxt  = ugcs_pkg::S_CNT_WR;
      end
      ugcs_pkg::S_CNT_WR: begin
        cmd.cnt_wr = 1'b1;
        if (sts.last) begin
          cmd.scan_init = 1'b1;
          state_nxt     = ugcs_pkg::S_SCAN;
        end else begin
          state_nxt = ugcs_pkg::S_IDLE;
        end
      end
      ugcs_pkg::S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (sts.scan_done) begin
          cmd.scat_init = 1'b1;
          state_nxt     = ugcs_pkg::S_SCAT_A;
        end
      end
      ugcs_pkg::S_SCAT_A: begin
        if (sts.scat_done) begin
          cmd.close = 1'b1;
          state_nxt = ugcs_pkg::S_IDLE;
        end else begin
          cmd.scat_rec = 1'b1;
          state_nxt    = ugcs_pkg::S_SCAT_B;
        end
      end
      ugcs_pkg::S_SCAT_B: begin
        cmd.scat_start = 1'b1;
        state_nxt      = ugcs_pkg::S_SCAT_C;
      end
      ugcs_pkg::S_SCAT_C: begin
        cmd.scat_wr = 1'b1;
        state_nxt   = ugcs_pkg::S_SCAT_A;
      end
      ugcs_pkg::S_RD_MAP: begin
        cmd.q_map = 1'b1;
        state_nxt = ugcs_pkg::S_RD_REC;
      end
      ugcs_pkg::S_RD_REC: begin
        cmd.q_rec = 1'b1;
        state_nxt = ugcs_pkg::S_RD_CELL;
      end
      ugcs_pkg::S_RD_CELL: begin
        cmd.q_cell = 1'b1;
        state_nxt  = ugcs_pkg::S_OUT;
      end
      ugcs_pkg::S_OUT: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = ugcs_pkg::S_IDLE;
        end
      end
      default: state_nxt = ugcs_pkg::S_IDLE;
    endcase
  end

  a_no_wr_full: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ugcs_pkg::S_CNT_WR |-> !sts.full)
    else $error("count update on full batch");

  a_clr_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ugcs_pkg::S_CLR && !sts.clr_done) |=> state_r == ugcs_pkg::S_CLR)
    else $error("clear sweep left early");

  a_out_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ugcs_pkg::S_OUT && !sts.out_busy) |=> state_r == ugcs_pkg::S_IDLE)
    else $error("result not retired");

endmodule

// ===== hw/rtl/ugcs_dp.sv =====
// Datapath: config registers, cell mapping, count/start/record/map RAMs,
// sweep counter and output register. Depends on ugcs_pkg and ugcs_ram.
module ugcs_dp #(
  parameter int MAX_PARTICLES = 4096,
  parameter int MAX_GRID_AXIS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [ugcs_pkg::CFG_W-1:0]         cfg_wdata,
  input  logic [1:0]                         in_opcode,
  input  logic [ugcs_pkg::ID_W-1:0]          in_particle_id,
  input  logic [ugcs_pkg::POS_W-1:0]         in_pos_x,
  input  logic [ugcs_pkg::POS_W-1:0]         in_pos_y,
  input  logic [ugcs_pkg::POS_W-1:0]         in_pos_z,
  input  logic signed [ugcs_pkg::VEL_W-1:0]  in_vel_x,
  input  logic signed [ugcs_pkg::VEL_W-1:0]  in_vel_y,
  input  logic signed [ugcs_pkg::VEL_W-1:0]  in_vel_z,
  input  logic                               in_last_particle,
  input  logic [ugcs_pkg::IDX_W-1:0]         in_lookup_index,
  input  ugcs_pkg::cmd_t                     cmd,
  output ugcs_pkg::sts_t                     sts,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_valid_res,
  output logic [ugcs_pkg::ID_W-1:0]          out_id,
  output logic [ugcs_pkg::POS_W-1:0]         out_pos_x,
  output logic [ugcs_pkg::POS_W-1:0]         out_pos_y,
  output logic [ugcs_pkg::POS_W-1:0]         out_pos_z,
  output logic signed [ugcs_pkg::VEL_W-1:0]  out_vel_x,
  output logic signed [ugcs_pkg::VEL_W-1:0]  out_vel_y,
  output logic signed [ugcs_pkg::VEL_W-1:0]  out_vel_z,
  output logic [ugcs_pkg::CELL_W-1:0]        out_cell,
  output logic [ugcs_pkg::SLOT_W-1:0]        out_cell_first_slot,
  output logic [ugcs_pkg::SLOT_W-1:0]        out_cell_members
);

  localparam int PW   = $clog2(MAX_PARTICLES);
  localparam int NW   = $clog2(MAX_PARTICLES + 1);
  localparam int GW   = $clog2(MAX_GRID_AXIS + 1);
  localparam int AW   = $clog2(MAX_GRID_AXIS);
  localparam int CSL  = MAX_GRID_AXIS * MAX_GRID_AXIS * MAX_GRID_AXIS;
  localparam int CW   = $clog2(CSL);
  localparam int CUW  = $clog2(CSL + 1);
  localparam int CTW  = (CUW > NW) ? CUW : NW;
  localparam int PAYW = $bits(ugcs_pkg::pay_t);
  localparam int RW   = CW + PW + PAYW;
  localparam int PRW  = ugcs_pkg::POS_W + ugcs_pkg::ICS_W;

  // configuration
  logic [ugcs_pkg::GPA_W-1:0] gpa_r;
  logic [ugcs_pkg::ICS_W-1:0] ics_r;
  logic [GW-1:0]              g_c;
  logic [GW-1:0]              gm1_c;
  logic [2*GW-1:0]            gg_r;
  logic [3*GW-1:0]            ggg_r;

  // latched item
  ugcs_pkg::op_t              op_r;
  ugcs_pkg::pay_t             pay_r;
  logic                       last_r;
  logic [ugcs_pkg::IDX_W-1:0] idx_r;

  logic [PRW-1:0] prx_r, pry_r, prz_r;
  logic [AW-1:0]  kx, ky, kz;
  logic [31:0]    c_full;
  logic [CW-1:0]  c_r;

  logic [NW-1:0]  bsize_r;
  logic           open_r;
  logic           ok_r;
  logic           ok_c;
  logic [CTW-1:0] ctr_r;
  logic           scan_issue;
  logic           sv_r;
  logic [CW-1:0]  sa_r;
  logic [NW-1:0]  run_r;
  logic [NW:0]    slot;

  logic           cnt_we, cnt_re, st_we, st_re, rec_we, rec_re, map_we;
  logic [CW-1:0]  cnt_wa, cnt_ra, st_ra;
  logic [NW-1:0]  cnt_wd, cnt_rd, st_rd;
  logic [PW-1:0]  rec_ra;
  logic [RW-1:0]  rec_rd;
  logic [PW-1:0]  map_rd;
  logic [CW-1:0]  rec_cell;
  logic [PW-1:0]  rec_rank;
  ugcs_pkg::pay_t rec_pay;
  logic [CW-1:0]  cell_q;

  logic                        out_valid_r;
  logic                        res_ok_r;
  ugcs_pkg::pay_t              res_pay_r;
  logic [ugcs_pkg::CELL_W-1:0] res_cell_r;
  logic [ugcs_pkg::SLOT_W-1:0] res_start_r;
  logic [ugcs_pkg::SLOT_W-1:0] res_mem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gpa_r <= ugcs_pkg::GPA_W'(16);
      ics_r <= ugcs_pkg::ICS_W'(256);
    end else if (cfg_we) begin
      case (cfg_index)
        ugcs_pkg::CFG_GRID: gpa_r <= cfg_wdata[ugcs_pkg::GPA_W-1:0];
        ugcs_pkg::CFG_INV:  ics_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (gpa_r == '0) begin
      g_c = GW'(1);
    end else if (32'(gpa_r) > MAX_GRID_AXIS) begin
      g_c = GW'(MAX_GRID_AXIS);
    end else begin
      g_c = GW'(gpa_r);
    end
    gm1_c = g_c - GW'(1);
  end

  always_ff @(posedge clk) begin
    gg_r  <= (2*GW)'(g_c) * (2*GW)'(g_c);
    ggg_r <= (3*GW)'(gg_r) * (3*GW)'(g_c);
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r     <= ugcs_pkg::op_t'(in_opcode);
      pay_r.id <= in_particle_id;
      pay_r.px <= in_pos_x;
      pay_r.py <= in_pos_y;
      pay_r.pz <= in_pos_z;
      pay_r.vx <= in_vel_x;
      pay_r.vy <= in_vel_y;
      pay_r.vz <= in_vel_z;
      last_r   <= in_last_particle;
      idx_r    <= in_lookup_index;
    end
    prx_r <= PRW'(pay_r.px) * PRW'(ics_r);
    pry_r <= PRW'(pay_r.py) * PRW'(ics_r);
    prz_r <= PRW'(pay_r.pz) * PRW'(ics_r);
  end

  always_comb begin
    kx = (prx_r[PRW-1:20] > (PRW-20)'(gm1_c)) ? AW'(gm1_c) : AW'(prx_r[PRW-1:20]);
    ky = (pry_r[PRW-1:20] > (PRW-20)'(gm1_c)) ? AW'(gm1_c) : AW'(pry_r[PRW-1:20]);
    kz = (prz_r[PRW-1:20] > (PRW-20)'(gm1_c)) ? AW'(gm1_c) : AW'(prz_r[PRW-1:20]);
    c_full = 32'(kx) + 32'(g_c) * 32'(ky) + 32'(gg_r) * 32'(kz);
  end

  always_comb begin
    ok_c = 1'b0;
    if (!open_r && bsize_r != '0) begin
      if (op_r == ugcs_pkg::OP_SLOT) begin
        ok_c = (32'(idx_r) < 32'(bsize_r)) && (32'(idx_r) < MAX_PARTICLES);
      end else if (op_r == ugcs_pkg::OP_CELL) begin
        ok_c = (32'(idx_r) < 32'(ggg_r)) && (32'(idx_r) < CSL);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cell_calc) begin
      c_r  <= CW'(c_full);
      ok_r <= ok_c;
    end
  end

  assign scan_issue = cmd.scan_run && (ctr_r < CTW'(CSL));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bsize_r <= '0;
      open_r  <= 1'b0;
      ctr_r   <= '0;
      sv_r    <= 1'b0;
      run_r   <= '0;
    end else begin
      sv_r <= scan_issue;
      if (cmd.clr_init) begin
        bsize_r <= '0;
        open_r  <= 1'b1;
      end else if (cmd.cnt_wr) begin
        bsize_r <= bsize_r + NW'(1);
      end
      if (cmd.close) begin
        open_r <= 1'b0;
      end
      if (cmd.clr_init || cmd.scan_init || cmd.scat_init) begin
        ctr_r <= '0;
      end else if (cmd.clr_run || scan_issue || cmd.scat_wr) begin
        ctr_r <= ctr_r + CTW'(1);
      end
      if (cmd.scan_init) begin
        run_r <= '0;
      end else if (sv_r) begin
        run_r <= run_r + cnt_rd;
      end
    end
  end

  always_ff @(posedge clk) begin
    sa_r <= ctr_r[CW-1:0];
  end

  assign rec_cell = rec_rd[RW-1 -: CW];
  assign rec_rank = rec_rd[PAYW +: PW];
  assign rec_pay  = ugcs_pkg::pay_t'(rec_rd[PAYW-1:0]);
  assign cell_q   = (op_r == ugcs_pkg::OP_SLOT) ? rec_cell : CW'(idx_r);
  assign slot     = {1'b0, st_rd} + (NW+1)'(rec_rank);

  assign cnt_we = cmd.clr_run || cmd.cnt_wr;
  assign cnt_wa = cmd.clr_run ? ctr_r[CW-1:0] : c_r;
  assign cnt_wd = cmd.clr_run ? '0 : cnt_rd + NW'(1);
  assign cnt_re = cmd.cnt_rd || scan_issue || cmd.q_cell;
  assign cnt_ra = cmd.cnt_rd ? c_r : (scan_issue ? ctr_r[CW-1:0] : cell_q);

  assign st_we = sv_r;
  assign st_re = cmd.scat_start || cmd.q_cell;
  assign st_ra = cmd.scat_start ? rec_cell : cell_q;

  assign rec_we = cmd.cnt_wr;
  assign rec_re = cmd.scat_rec || cmd.q_rec;
  assign rec_ra = cmd.scat_rec ? ctr_r[PW-1:0] : map_rd;

  assign map_we = cmd.scat_wr && (32'(slot) < MAX_PARTICLES);

  ugcs_ram #(.W(NW), .D(CSL)) u_cnt (
    .clk(clk), .we(cnt_we), .wa(cnt_wa), .wd(cnt_wd),
    .re(cnt_re), .ra(cnt_ra), .rd(cnt_rd)
  );

  ugcs_ram #(.W(NW), .D(CSL)) u_start (
    .clk(clk), .we(st_we), .wa(sa_r), .wd(run_r),
    .re(st_re), .ra(st_ra), .rd(st_rd)
  );

  ugcs_ram #(.W(RW), .D(MAX_PARTICLES)) u_rec (
    .clk(clk), .we(rec_we), .wa(bsize_r[PW-1:0]),
    .wd({c_r, PW'(cnt_rd), pay_r}),
    .re(rec_re), .ra(rec_ra), .rd(rec_rd)
  );

  ugcs_ram #(.W(PW), .D(MAX_PARTICLES)) u_map (
    .clk(clk), .we(map_we), .wa(slot[PW-1:0]), .wd(ctr_r[PW-1:0]),
    .re(cmd.q_map), .ra(PW'(idx_r)), .rd(map_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res_ok_r    <= ok_r;
      res_pay_r   <= '0;
      res_cell_r  <= '0;
      res_start_r <= '0;
      res_mem_r   <= '0;
      if (ok_r) begin
        if (op_r == ugcs_pkg::OP_SLOT) begin
          res_pay_r <= rec_pay;
        end
        res_cell_r  <= ugcs_pkg::CELL_W'(cell_q);
        res_start_r <= ugcs_pkg::SLOT_W'(st_rd);
        res_mem_r   <= ugcs_pkg::SLOT_W'(cnt_rd);
      end
    end
  end

  always_comb begin
    sts           = '0;
    sts.open      = open_r;
    sts.full      = (32'(bsize_r) == MAX_PARTICLES);
    sts.last      = last_r;
    sts.op        = op_r;
    sts.rd_ok     = ok_c;
    sts.clr_done  = (ctr_r == CTW'(CSL - 1));
    sts.scan_done = (ctr_r == CTW'(CSL)) && !sv_r;
    sts.scat_done = (ctr_r >= CTW'(bsize_r));
    sts.out_busy  = out_valid_r && out_stall;
  end

  assign out_valid           = out_valid_r;
  assign out_valid_res       = res_ok_r;
  assign out_id              = res_pay_r.id;
  assign out_pos_x           = res_pay_r.px;
  assign out_pos_y           = res_pay_r.py;
  assign out_pos_z           = res_pay_r.pz;
  assign out_vel_x           = res_pay_r.vx;
  assign out_vel_y           = res_pay_r.vy;
  assign out_vel_z           = res_pay_r.vz;
  assign out_cell            = res_cell_r;
  assign out_cell_first_slot = res_start_r;
  assign out_cell_members    = res_mem_r;

  a_bsize_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_wr |-> (32'(bsize_r) < MAX_PARTICLES))
    else $error("record written past capacity");

endmodule
